// ----- sv/chce_pkg.sv -----
// ---------------------------------------------------------------------------
// chce_pkg: shared definitions for the cubic Hermite curve evaluator
// Register indexes, output field widths and the quadrature tables.
// ---------------------------------------------------------------------------
package chce_pkg;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_START_POINT    = 2'd0,
		REG_START_VELOCITY = 2'd1,
		REG_END_POINT      = 2'd2,
		REG_END_VELOCITY   = 2'd3
	} reg_idx_t;

	// Each result field is Q16.8 in 24 bits; seven fields per beat.
	localparam int OUT_W    = 24;
	localparam int OUT_BITS = 7 * OUT_W;

	// Five-point Gauss-Legendre rule: node positions (x+1)/2 and half
	// weights, both in Q0.16.
	localparam int NODES = 5;
	localparam logic [15:0] NODE_FRAC [NODES] = '{
		16'd32768, 16'd50413, 16'd15123, 16'd62462, 16'd3074
	};
	localparam logic [14:0] HALF_WEIGHT [NODES] = '{
		15'd18641, 15'd15684, 15'd15684, 15'd7764, 15'd7764
	};

endpackage

// ----- sv/cubic_hermite_curve_eval_top.sv -----
// ---------------------------------------------------------------------------
// cubic_hermite_curve_eval_top: cubic Hermite segment evaluator
// Returns point, tangent and Gauss-Legendre arc length for each t.
// ---------------------------------------------------------------------------
//
// Channel   Signals                               Contents
// s_axis    tvalid tready tdata                   curve_param t, Q1.PARAM_FRAC_BITS
// m_axis    tvalid tready tdata                   point, tangent, arc_length
// config    wr_en wr_index wr_data                four segment registers
//
// One beat enters per cycle unless a stall on m_axis has filled the
// pipeline. The square root takes most of the stages; it resolves one root
// bit per stage over COORD_BITS+6 stages.
// Reset clears all stage valid bits and the segment registers.
// Each stage holds its beat while the stage after it is full and held, so a
// stall on m_axis fills the bubbles before s_axis_tready drops.
module cubic_hermite_curve_eval_top #(
	parameter int COORD_BITS      = 16,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Fields from bit 0: curve_param, zero fill.
	input  logic [((PARAM_FRAC_BITS+8)/8)*8-1:0] s_axis_tdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0: point_x, point_y, point_z, tangent_x, tangent_y,
	// tangent_z, arc_length.
	output logic [chce_pkg::OUT_BITS-1:0]    m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             wr_en,
	input  chce_pkg::reg_idx_t               wr_index,
	input  logic [3*COORD_BITS-1:0]          wr_data
);
	import chce_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int PB  = PARAM_FRAC_BITS;
	localparam int TW  = PB + 1;            // t width
	localparam int W   = CB + 6;            // internal signed value width
	localparam int PW  = W + TW + 1;        // product of value and t
	localparam int SQ  = 2 * W;             // sum of squares width
	localparam int AW  = W + 18;            // weighted sum width
	localparam int SW  = W + 3;             // rounded weighted sum width
	localparam int LPW = SW + TW + 1;       // length product width
	localparam int LW  = LPW - PB;          // length before saturation
	localparam int NL  = NODES + 1;         // tangent lanes: t, then nodes
	localparam int NS  = W + 9;             // number of stages
	localparam int XW  = (W > 25) ? W : 25;
	localparam int XL  = (LW > 25) ? LW : 25;
	localparam logic signed [PW-1:0] RND  = PW'(1) << (PB - 1);
	localparam logic [TW-1:0]        ONE  = TW'(1) << PB;
	localparam logic signed [XW-1:0] SMAX = XW'(8388607);
	localparam logic signed [XW-1:0] SMIN = -XW'(8388608);
	localparam logic [XL-1:0]        UMAX = XL'(24'hFFFFFF);

	typedef struct packed {
		logic [TW-1:0]      tu;
		logic [6*OUT_W-1:0] pt_tg;   // px, py, pz, tx, ty, tz from bit 0
	} side_t;

	typedef struct packed {
		logic signed [W-1:0] c0;
		logic signed [W-1:0] c1;
		logic signed [W-1:0] c2;
		logic signed [W-1:0] c3;
		logic signed [W-1:0] c2x2;
		logic signed [W-1:0] c3x3;
	} coef_t;

	// Product with t, rounded half up back to the value's scale.
	function automatic logic signed [W-1:0] rmul(input logic signed [W-1:0] a,
			input logic [TW-1:0] p);
		logic signed [PW-1:0] pr;
		pr = PW'(a) * PW'($signed({1'b0, p}));
		pr = pr + RND;
		return W'(pr >>> PB);
	endfunction

	function automatic logic [OUT_W-1:0] sat24(input logic signed [W-1:0] v);
		logic signed [XW-1:0] x;
		x = XW'(v);
		if (x > SMAX)
			x = SMAX;
		else if (x < SMIN)
			x = SMIN;
		return x[OUT_W-1:0];
	endfunction

	function automatic logic signed [W-1:0] comp(input logic [3*CB-1:0] r, input int k);
		logic signed [CB-1:0] f;
		f = r[k*CB +: CB];
		return W'(f);
	endfunction

	logic [3*CB-1:0] start_point_q, start_velocity_q, end_point_q, end_velocity_q;
	coef_t           cf_d [3];
	coef_t           cf_q [3];
	logic [NS:1]     v;
	logic [NS:1]     en;

	logic [TW-1:0]          t_in;
	logic [TW-1:0]          t_s1 [NL];
	logic [TW-1:0]          t_s2 [NL];
	logic [TW-1:0]          t_s3;
	logic [TW-1:0]          t_s4;
	logic signed [W-1:0]    pa_s2 [3];
	logic signed [W-1:0]    ta_s2 [NL][3];
	logic signed [W-1:0]    pa_s3 [3];
	logic signed [W-1:0]    td_s3 [NL][3];
	logic signed [W-1:0]    pt_s4 [3];
	logic signed [W-1:0]    tg_s4 [3];
	logic [SQ-1:0]          sqr_s4 [NODES][3];
	logic [SQ-1:0]          rem_s  [W+1][NODES];
	logic [SQ-1:0]          root_s [W+1][NODES];
	side_t                  sd_s   [W+1];
	logic [W+14:0]          prod_s_w1 [NODES];
	side_t                  sd_w1, sd_w2, sd_w3;
	logic [SW-1:0]          s8_w2;
	logic [LW-1:0]          len_w3;
	logic [OUT_BITS-1:0]    out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_point_q    <= '0;
			start_velocity_q <= '0;
			end_point_q      <= '0;
			end_velocity_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_POINT:    start_point_q    <= wr_data;
				REG_START_VELOCITY: start_velocity_q <= wr_data;
				REG_END_POINT:      end_point_q      <= wr_data;
				REG_END_VELOCITY:   end_velocity_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// Hermite coefficients per component.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [W-1:0] p0, v0, p1, v1;
			p0 = comp(start_point_q, k);
			v0 = comp(start_velocity_q, k);
			p1 = comp(end_point_q, k);
			v1 = comp(end_velocity_q, k);
			cf_d[k].c0   = p0;
			cf_d[k].c1   = v0;
			cf_d[k].c2   = W'(3 * (p1 - p0) - 2 * v0 - v1);
			cf_d[k].c3   = W'(2 * (p0 - p1) + v0 + v1);
			cf_d[k].c2x2 = W'(2 * cf_d[k].c2);
			cf_d[k].c3x3 = W'(3 * cf_d[k].c3);
		end
	end

	// Stage enables: a stage loads when it is empty or its successor moves.
	always_comb begin
		en[NS] = !v[NS] || m_axis_tready;
		for (int i = NS - 1; i >= 1; i--)
			en[i] = !v[i] || en[i+1];
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			if (en[1])
				v[1] <= s_axis_tvalid;
			for (int i = 2; i <= NS; i++)
				if (en[i])
					v[i] <= v[i-1];
		end
	end

	// Stage 1: clamp t, form the quadrature node parameters.
	assign t_in = (s_axis_tdata[TW-1:0] > ONE) ? ONE : s_axis_tdata[TW-1:0];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s1[0] <= t_in;
			for (int i = 0; i < NODES; i++)
				t_s1[i+1] <= TW'(((TW+17)'(t_in) * (TW+17)'(NODE_FRAC[i])
					+ (TW+17)'(32768)) >> 16);
			for (int k = 0; k < 3; k++)
				cf_q[k] <= cf_d[k];
		end
	end

	// Stage 2: first Horner step for the point and every tangent lane.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int l = 0; l < NL; l++)
				t_s2[l] <= t_s1[l];
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= rmul(cf_q[k].c3, t_s1[0]) + cf_q[k].c2;
				for (int l = 0; l < NL; l++)
					ta_s2[l][k] <= rmul(cf_q[k].c3x3, t_s1[l]) + cf_q[k].c2x2;
			end
		end
	end

	// Stage 3: second Horner step; tangents complete here.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s3 <= t_s2[0];
			for (int k = 0; k < 3; k++) begin
				pa_s3[k] <= rmul(pa_s2[k], t_s2[0]) + cf_q[k].c1;
				for (int l = 0; l < NL; l++)
					td_s3[l][k] <= rmul(ta_s2[l][k], t_s2[l]) + cf_q[k].c1;
			end
		end
	end

	// Stage 4: last point step and the squared node tangents.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s4 <= t_s3;
			for (int k = 0; k < 3; k++) begin
				pt_s4[k] <= rmul(pa_s3[k], t_s3) + cf_q[k].c0;
				tg_s4[k] <= td_s3[0][k];
				for (int i = 0; i < NODES; i++)
					sqr_s4[i][k] <= SQ'(td_s3[i+1][k] * td_s3[i+1][k]);
			end
		end
	end

	// Stage 5: saturate point and tangent, sum the squares.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			sd_s[0].tu <= t_s4;
			for (int k = 0; k < 3; k++) begin
				sd_s[0].pt_tg[k*OUT_W +: OUT_W]       <= sat24(pt_s4[k]);
				sd_s[0].pt_tg[(k+3)*OUT_W +: OUT_W]   <= sat24(tg_s4[k]);
			end
			for (int i = 0; i < NODES; i++) begin
				rem_s[0][i]  <= sqr_s4[i][0] + sqr_s4[i][1] + sqr_s4[i][2];
				root_s[0][i] <= '0;
			end
		end
	end

	// Square root stages: one result bit per stage, restoring method.
	for (genvar j = 0; j < W; j++) begin : g_root
		localparam logic [SQ-1:0] BIT = SQ'(1) << (SQ - 2 - 2 * j);
		always_ff @(posedge clk) begin
			if (en[6+j]) begin
				sd_s[j+1] <= sd_s[j];
				for (int i = 0; i < NODES; i++) begin
					if (rem_s[j][i] >= root_s[j][i] + BIT) begin
						rem_s[j+1][i]  <= rem_s[j][i] - (root_s[j][i] + BIT);
						root_s[j+1][i] <= (root_s[j][i] >> 1) + BIT;
					end else begin
						rem_s[j+1][i]  <= rem_s[j][i];
						root_s[j+1][i] <= root_s[j][i] >> 1;
					end
				end
			end
		end
	end

	// Weight each node magnitude.
	always_ff @(posedge clk) begin
		if (en[W+6]) begin
			sd_w1 <= sd_s[W];
			for (int i = 0; i < NODES; i++)
				prod_s_w1[i] <= (W+15)'(root_s[W][i][W-1:0]) * (W+15)'(HALF_WEIGHT[i]);
		end
	end

	// Sum the weighted magnitudes and round to 8 fraction bits.
	always_ff @(posedge clk) begin
		if (en[W+7]) begin
			sd_w2 <= sd_w1;
			s8_w2 <= SW'(((AW+1)'(prod_s_w1[0]) + (AW+1)'(prod_s_w1[1])
				+ (AW+1)'(prod_s_w1[2]) + (AW+1)'(prod_s_w1[3])
				+ (AW+1)'(prod_s_w1[4]) + (AW+1)'(32768)) >> 16);
		end
	end

	// Scale by t with rounding.
	always_ff @(posedge clk) begin
		if (en[W+8]) begin
			sd_w3  <= sd_w2;
			len_w3 <= LW'(((LPW)'(s8_w2) * (LPW)'(sd_w2.tu) + (LPW)'(ONE >> 1)) >> PB);
		end
	end

	// Output register with length saturation.
	always_ff @(posedge clk) begin
		if (en[NS])
			out_q <= {((XL'(len_w3) > UMAX) ? 24'hFFFFFF : len_w3[OUT_W-1:0]), sd_w3.pt_tg};
	end

	assign m_axis_tvalid = v[NS];
	assign m_axis_tdata  = out_q;

endmodule

// ----- sv/chce_checker.sv -----
// ---------------------------------------------------------------------------
// chce_assertions: port-level checks for the curve evaluator
// Watches the stream handshakes and the stall behavior of the pipeline.
// ---------------------------------------------------------------------------
module chce_assertions (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [chce_pkg::OUT_BITS-1:0] m_axis_tdata,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready
);
	import chce_pkg::*;

	// A result beat that is not taken stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// With the output draining, no stage can hold back the input.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

	// An empty output stage always frees the pipeline.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output");

	// The input only stalls while a result beat waits at the output.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without an output stall");

endmodule

bind cubic_hermite_curve_eval_top chce_assertions u_chce_assertions (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
